### rtl/scd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the set change detector
// Store geometry, outcome codes, the search token that travels along the
// cell chain and the maintenance port that the sequencer drives.
// ----------------------------------------------------------------------------
package scd_pkg;

  // store geometry: entries interleaved over the cells, cell = low index bits
  localparam int CAPACITY  = 4096;
  localparam int CELLS     = 8;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int ROW_W     = IDX_W - CELL_W;
  localparam int ROWS      = CAPACITY / CELLS;

  // payload widths
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 13;
  localparam int OUTCOME_W = 3;

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NEW      = 3'd0,
    OUT_OLD      = 3'd1,
    OUT_ALREADY  = 3'd2,
    OUT_FULL     = 3'd3,
    OUT_ROLLOVER = 3'd4
  } outcome_t;

  // one row of the sweep, with the hit found so far
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [ROW_W-1:0] row;
    logic             found;
    logic [IDX_W-1:0] hit_idx;
  } token_t;

  // what every cell compares against during a sweep
  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic [COUNT_W-1:0] limit;
  } search_t;

  // sequencer access to the banks outside a sweep
  typedef struct packed {
    logic               sel;
    logic               we;
    logic [CELL_W-1:0]  bank;
    logic [ROW_W-1:0]   row;
    logic [VALUE_W-1:0] data;
  } maint_t;

  function automatic logic [COUNT_W-1:0] idx_to_count(input logic [IDX_W-1:0] idx);
    return {{(COUNT_W - IDX_W){1'b0}}, idx};
  endfunction

  function automatic logic [CELL_W-1:0] cell_pos(input int c);
    return c[CELL_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/scd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_in_if: request channel of the set change detector
// Valid/ready handshake carrying the mode and the value of one request.
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [scd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface
`default_nettype wire

### rtl/scd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_out_if: result channel of the set change detector
// Valid/ready handshake carrying the outcome code and both region lengths.
// ----------------------------------------------------------------------------
interface scd_out_if;
  logic                           valid;
  logic                           ready;
  logic [scd_pkg::OUTCOME_W-1:0]  outcome;
  logic [scd_pkg::COUNT_W-1:0]    new_count;
  logic [scd_pkg::COUNT_W-1:0]    old_count;

  modport source (output valid, output outcome, output new_count, output old_count,
                  input ready);
  modport sink   (input valid, input outcome, input new_count, input old_count,
                  output ready);
endinterface
`default_nettype wire

### rtl/scd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/scd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_cell: one cell of the search chain
// Owns one bank of the store (every CELLS-th entry). Reads the row named by
// the incoming token, compares the entry with the key and passes the token
// on, with any hit merged in, through its stage and output registers.
// ----------------------------------------------------------------------------
module scd_cell (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire [scd_pkg::CELL_W-1:0]           pos,
  input  wire scd_pkg::search_t               search,
  input  wire scd_pkg::maint_t                maint,
  input  wire scd_pkg::token_t                tok_in,
  output scd_pkg::token_t                     tok_out,
  output logic [scd_pkg::VALUE_W-1:0]         rd_data
);

  scd_pkg::token_t             stage;
  logic [scd_pkg::ROW_W-1:0]   raddr;
  logic                        we;
  logic [scd_pkg::IDX_W-1:0]   idx;
  logic                        in_range;
  logic                        hit;

  // bank address: sweep row, or sequencer row during a fetch
  assign raddr = maint.sel ? maint.row : tok_in.row;
  assign we    = maint.we && (maint.bank == pos);

  scd_ram #(
    .WIDTH (scd_pkg::VALUE_W),
    .DEPTH (scd_pkg::ROWS)
  ) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (maint.row),
    .wdata (maint.data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // hold the token while the bank read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage <= tok_in;
    end
  end

  // compare only entries inside both regions
  assign idx      = {stage.row, pos};
  assign in_range = scd_pkg::idx_to_count(idx) < search.limit;
  assign hit      = stage.valid && in_range && (rd_data == search.key);

  // pass the token on with the hit merged in
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid   <= stage.valid;
      tok_out.last    <= stage.last;
      tok_out.row     <= stage.row;
      tok_out.found   <= stage.found | hit;
      tok_out.hit_idx <= hit ? idx : stage.hit_idx;
    end
  end

endmodule
`default_nettype wire

### rtl/set_change_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_change_detector: new/old set tracker over one interleaved store
// Keeps a store of 32-bit values split into a new region followed by an old
// region and reports, for each request, how the value related to them.
// ----------------------------------------------------------------------------
// Usage:
//   items   : request channel (mode, value); mode 1 is a rollover.
//   results : one result per request (outcome, new_count, old_count).
//   A request is taken only when the previous one has left the sequencer;
//   its result waits in an output register, so the next request is taken
//   while the receiver stalls. A full output register holds the sequencer
//   in its final step until the result is taken.
//   Rollover: goes from accept straight to the final step.
//   Insert over n stored entries: the eight cells sweep one row of eight
//   entries a cycle, each row passing through the stage and output
//   registers of every cell; the chain then drains. The result follows
//   when the value was already present or the store is full; otherwise
//   the store is first rewritten (fetch of the first old entry and two
//   writes). With an empty store the sweep is skipped.
//   Reset clears both lengths and the control state; the store is not
//   cleared, since every entry inside the two regions has been written.
// ----------------------------------------------------------------------------
module set_change_detector (
  input  wire       clk,
  input  wire       rst,
  scd_in_if.sink    items,
  scd_out_if.source results
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_DRAIN  = 8'b0000_0100,
    ST_FETCH  = 8'b0000_1000,
    ST_LOAD   = 8'b0001_0000,
    ST_COPY   = 8'b0010_0000,
    ST_PLACE  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t                          state;
  scd_pkg::outcome_t               outcome;
  scd_pkg::outcome_t               verdict;
  logic [scd_pkg::VALUE_W-1:0]     key;
  logic [scd_pkg::VALUE_W-1:0]     first_old;
  logic [scd_pkg::COUNT_W-1:0]     new_len;
  logic [scd_pkg::COUNT_W-1:0]     old_len;
  logic [scd_pkg::COUNT_W-1:0]     new_len_next;
  logic [scd_pkg::COUNT_W-1:0]     old_len_next;
  logic [scd_pkg::COUNT_W-1:0]     limit;
  logic [scd_pkg::COUNT_W-1:0]     total;
  logic [scd_pkg::COUNT_W-1:0]     total_m1;
  logic [scd_pkg::ROW_W-1:0]       row_cnt;
  logic [scd_pkg::ROW_W-1:0]       last_row;
  logic                            found;
  logic [scd_pkg::IDX_W-1:0]       hit_idx;
  logic                            all_found;
  logic [scd_pkg::IDX_W-1:0]       all_idx;
  logic [scd_pkg::IDX_W-1:0]       maddr;
  logic                            out_valid;
  logic                            out_load;
  scd_pkg::outcome_t               out_outcome;
  logic [scd_pkg::COUNT_W-1:0]     out_new;
  logic [scd_pkg::COUNT_W-1:0]     out_old;

  scd_pkg::search_t                search;
  scd_pkg::maint_t                 maint;
  scd_pkg::token_t                 tok [scd_pkg::CELLS+1];
  logic [scd_pkg::VALUE_W-1:0]     bank_data [scd_pkg::CELLS];

  assign items.ready       = (state == ST_IDLE);
  assign results.valid     = out_valid;
  assign results.outcome   = out_outcome;
  assign results.new_count = out_new;
  assign results.old_count = out_old;

  assign total    = new_len + old_len;
  assign total_m1 = total - scd_pkg::COUNT_W'(1);

  // search broadcast and sweep injection into the first cell
  assign search.key   = key;
  assign search.limit = limit;

  assign tok[0] = '{valid:   (state == ST_SEARCH),
                    last:    (row_cnt == last_row),
                    row:     row_cnt,
                    found:   1'b0,
                    hit_idx: '0};

  // chain of cells, one bank each
  for (genvar c = 0; c < scd_pkg::CELLS; c++) begin : g_cell
    scd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (scd_pkg::cell_pos(c)),
      .search  (search),
      .maint   (maint),
      .tok_in  (tok[c]),
      .tok_out (tok[c+1]),
      .rd_data (bank_data[c])
    );
  end

  // merge the tail token into the hit seen so far and classify
  assign all_found = found | tok[scd_pkg::CELLS].found;
  assign all_idx   = tok[scd_pkg::CELLS].found ? tok[scd_pkg::CELLS].hit_idx : hit_idx;

  always_comb begin
    if (all_found) begin
      verdict = (scd_pkg::idx_to_count(all_idx) < new_len) ? scd_pkg::OUT_ALREADY
                                                          : scd_pkg::OUT_OLD;
    end else begin
      verdict = (limit == scd_pkg::CAP_COUNT) ? scd_pkg::OUT_FULL : scd_pkg::OUT_NEW;
    end
  end

  // sequencer access: fetch first old entry, move it, place the value
  always_comb begin
    unique case (state)
      ST_COPY: maddr = (outcome == scd_pkg::OUT_OLD) ? hit_idx
                                                     : limit[scd_pkg::IDX_W-1:0];
      default: maddr = new_len[scd_pkg::IDX_W-1:0];
    endcase
    maint.sel  = (state == ST_FETCH);
    maint.we   = (state == ST_COPY) || (state == ST_PLACE);
    maint.bank = maddr[scd_pkg::CELL_W-1:0];
    maint.row  = maddr[scd_pkg::IDX_W-1:scd_pkg::CELL_W];
    maint.data = (state == ST_COPY) ? first_old : key;
  end

  // region lengths after the request
  always_comb begin
    new_len_next = new_len;
    old_len_next = old_len;
    case (outcome)
      scd_pkg::OUT_ROLLOVER: begin
        new_len_next = '0;
        old_len_next = new_len;
      end
      scd_pkg::OUT_NEW: begin
        new_len_next = new_len + scd_pkg::COUNT_W'(1);
      end
      scd_pkg::OUT_OLD: begin
        new_len_next = new_len + scd_pkg::COUNT_W'(1);
        old_len_next = old_len - scd_pkg::COUNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register loads when the sequencer finishes and the slot is free or being taken
  assign out_load = (state == ST_DONE) && (!out_valid || results.ready);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      new_len   <= '0;
      old_len   <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (items.valid) begin
            key      <= $unsigned(items.value);
            limit    <= total;
            found    <= 1'b0;
            row_cnt  <= '0;
            last_row <= total_m1[scd_pkg::IDX_W-1:scd_pkg::CELL_W];
            if (items.mode) begin
              outcome <= scd_pkg::OUT_ROLLOVER;
              state   <= ST_DONE;
            end else if (total == '0) begin
              outcome <= scd_pkg::OUT_NEW;
              state   <= ST_FETCH;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // early rows already leave the chain while the sweep goes on
          if (tok[scd_pkg::CELLS].valid) begin
            found   <= all_found;
            hit_idx <= all_idx;
          end
          row_cnt <= row_cnt + scd_pkg::ROW_W'(1);
          if (row_cnt == last_row) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tok[scd_pkg::CELLS].valid) begin
            found   <= all_found;
            hit_idx <= all_idx;
            if (tok[scd_pkg::CELLS].last) begin
              outcome <= verdict;
              if (verdict == scd_pkg::OUT_NEW || verdict == scd_pkg::OUT_OLD) begin
                state <= ST_FETCH;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          first_old <= bank_data[new_len[scd_pkg::CELL_W-1:0]];
          state     <= ST_COPY;
        end
        ST_COPY: begin
          state <= ST_PLACE;
        end
        ST_PLACE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_outcome <= outcome;
            out_new     <= new_len_next;
            out_old     <= old_len_next;
            new_len     <= new_len_next;
            old_len     <= old_len_next;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/scd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_checker: port-level checks of the set change detector
// Watches the result channel for length and outcome consistency.
// ----------------------------------------------------------------------------
module scd_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [scd_pkg::OUTCOME_W-1:0]     outcome,
  input wire [scd_pkg::COUNT_W-1:0]       new_count,
  input wire [scd_pkg::COUNT_W-1:0]       old_count
);

  logic [scd_pkg::COUNT_W:0] sum;

  assign sum = {1'b0, new_count} + {1'b0, old_count};

  // both regions together never exceed the store
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sum <= {1'b0, scd_pkg::CAP_COUNT})
    else $error("region lengths exceed capacity");

  // a full report only when the store is exactly full
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == scd_pkg::OUT_FULL) |-> sum == {1'b0, scd_pkg::CAP_COUNT})
    else $error("full reported on a store with room");

  // rollover leaves the new region empty
  a_rollover: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == scd_pkg::OUT_ROLLOVER) |-> new_count == '0)
    else $error("new region not empty after rollover");

  // a value entering the new region leaves it non-empty
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == scd_pkg::OUT_NEW || outcome == scd_pkg::OUT_OLD))
      |-> new_count != '0)
    else $error("new region empty after insert");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(outcome) && $stable(new_count) && $stable(old_count)))
    else $error("result changed while stalled");

endmodule

bind set_change_detector scd_checker u_scd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .outcome   (results.outcome),
  .new_count (results.new_count),
  .old_count (results.old_count)
);
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the set change detector
// Drives insert and rollover requests through the request channel, tracks
// the new and old regions in a shadow copy of the store and checks every
// result for outcome code and both region lengths. Covers directed corner
// cases and random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_ROLLOVER = 1'b1;
  localparam int   DRAIN_CYCLES  = 600;
  localparam int   POOL_SIZE     = 20;
  localparam int   MAX_PRINTS    = 50;

  typedef struct {
    scd_pkg::outcome_t           outcome;
    logic [scd_pkg::COUNT_W-1:0] new_count;
    logic [scd_pkg::COUNT_W-1:0] old_count;
  } set_report_t;

  logic clk;
  logic rst;

  scd_in_if  item_ch ();
  scd_out_if result_ch ();

  set_change_detector u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch)
  );

  // shadow of the store and both region lengths
  logic [scd_pkg::VALUE_W-1:0] shadow_store [scd_pkg::CAPACITY];
  int                          shadow_new_len;
  int                          shadow_old_len;

  set_report_t pending_reports [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #150_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // apply one request to the shadow regions and return the expected result
  function automatic set_report_t track_request(input logic mode,
                                                input logic [scd_pkg::VALUE_W-1:0] value);
    set_report_t rep;
    int          stop;
    int          hit_at;
    logic        in_new;
    rep.outcome = scd_pkg::OUT_NEW;
    stop        = shadow_new_len + shadow_old_len;
    hit_at      = -1;
    in_new      = 1'b0;
    if (mode == MODE_ROLLOVER) begin
      shadow_old_len = shadow_new_len;
      shadow_new_len = 0;
      rep.outcome    = scd_pkg::OUT_ROLLOVER;
    end else begin
      for (int k = 0; k < shadow_new_len; k++) begin
        if (shadow_store[k] == value) in_new = 1'b1;
      end
      if (in_new) begin
        rep.outcome = scd_pkg::OUT_ALREADY;
      end else begin
        for (int k = shadow_new_len; k < stop; k++) begin
          if (hit_at < 0 && shadow_store[k] == value) hit_at = k;
        end
        if (hit_at >= 0) begin
          // swap the hit with the first old entry, it joins the new region
          shadow_store[hit_at]         = shadow_store[shadow_new_len];
          shadow_store[shadow_new_len] = value;
          shadow_new_len++;
          shadow_old_len--;
          rep.outcome = scd_pkg::OUT_OLD;
        end else if (stop >= scd_pkg::CAPACITY) begin
          rep.outcome = scd_pkg::OUT_FULL;
        end else begin
          // first old entry moves to the end, value takes its slot
          shadow_store[stop]           = shadow_store[shadow_new_len];
          shadow_store[shadow_new_len] = value;
          shadow_new_len++;
          rep.outcome = scd_pkg::OUT_NEW;
        end
      end
    end
    rep.new_count = scd_pkg::COUNT_W'(shadow_new_len);
    rep.old_count = scd_pkg::COUNT_W'(shadow_old_len);
    return rep;
  endfunction

  // send one request; valid stays high into the next request unless idling
  task automatic send_request(input logic mode, input logic [scd_pkg::VALUE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode  <= mode;
    item_ch.value <= value;
    do @(posedge clk); while (!item_ch.ready);
    pending_reports.push_back(track_request(mode, value));
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin : result_check
    set_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_reports.pop_front();
        if (result_ch.outcome !== want.outcome)
          report_mismatch($sformatf("outcome %0d, expected %0d",
                                    result_ch.outcome, want.outcome));
        if (result_ch.new_count !== want.new_count)
          report_mismatch($sformatf("new_count %0d, expected %0d",
                                    result_ch.new_count, want.new_count));
        if (result_ch.old_count !== want.old_count)
          report_mismatch($sformatf("old_count %0d, expected %0d",
                                    result_ch.old_count, want.old_count));
      end
    end
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // corner values, every outcome but full, empty and non-empty old region
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(MODE_ROLLOVER, 32'h5A5A_5A5A);
    send_request(MODE_INSERT,   32'h0000_0000);
    send_request(MODE_INSERT,   32'h0000_0000);
    send_request(MODE_INSERT,   32'h7FFF_FFFF);
    send_request(MODE_INSERT,   32'h8000_0000);
    send_request(MODE_INSERT,   32'hFFFF_FFFF);
    send_request(MODE_INSERT,   32'h0000_0001);
    send_request(MODE_ROLLOVER, 32'hFFFF_FFFF);
    send_request(MODE_INSERT,   32'h8000_0000);
    send_request(MODE_INSERT,   32'h8000_0000);
    send_request(MODE_INSERT,   32'h1234_5678);
    send_request(MODE_INSERT,   32'h0000_0000);
    send_request(MODE_INSERT,   32'hFFFF_FFFF);
    send_request(MODE_INSERT,   32'h0000_0001);
    send_request(MODE_INSERT,   32'h7FFF_FFFF);
    send_request(MODE_INSERT,   32'h5555_5555);
    send_request(MODE_INSERT,   32'hAAAA_AAAA);
    send_request(MODE_ROLLOVER, 32'h0000_0000);
    send_request(MODE_INSERT,   32'h1234_5678);
    send_request(MODE_ROLLOVER, 32'h8000_0000);
    send_request(MODE_INSERT,   32'h0000_0000);
    send_request(MODE_ROLLOVER, 32'h7FFF_FFFF);
    send_request(MODE_ROLLOVER, 32'h0000_0000);
  endtask

  // mostly values from a small pool so hits in both regions are common
  task automatic test_random_traffic();
    logic [scd_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
    int                          pick;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int n = 0; n < 30; n++) begin
        pick = $urandom_range(99);
        if (pick < 10)
          send_request(MODE_ROLLOVER, $urandom);
        else if (pick < 80)
          send_request(MODE_INSERT, value_pool[$urandom_range(POOL_SIZE - 1)]);
        else
          send_request(MODE_INSERT, $urandom);
      end
    end
  endtask

  // main sequence
  initial begin
    rst             = 1'b1;
    error_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    shadow_new_len  = 0;
    shadow_old_len  = 0;
    item_ch.valid   <= 1'b0;
    item_ch.mode    <= MODE_INSERT;
    item_ch.value   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();

    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/scd_pkg.sv
rtl/scd_in_if.sv
rtl/scd_out_if.sv
rtl/scd_ram.sv
rtl/scd_cell.sv
rtl/set_change_detector.sv
rtl/scd_checker.sv
tb/sv/testbench.sv
